// ===== rtl/core/y2r_pkg.sv =====
// y2r_pkg: shared types, register indexes and BT.601 coefficients for the
// 4:2:0 block to RGB converter. No dependencies.
`timescale 1ns / 1ps

package y2r_pkg;

  localparam int unsigned LUMA_W   = 8;
  localparam int unsigned PIXEL_W  = 24;
  localparam int unsigned GRID_W   = 12;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 12;

  typedef logic signed [25:0] offset_t;
  typedef logic signed [26:0] chan_sum_t;

  localparam offset_t COEF_RV = 26'sd91881;
  localparam offset_t COEF_GU = -26'sd22553;
  localparam offset_t COEF_GV = -26'sd46801;
  localparam offset_t COEF_BU = 26'sd116129;

  localparam chan_sum_t CLIP_HIGH = 27'sd16777215;
  localparam chan_sum_t CLIP_LOW  = 27'sd65535;

  localparam logic [GRID_W-1:0] GRID_MAX = 12'd2048;
  localparam logic [GRID_W-1:0] BLOCKS_PER_ROW_RST = 12'd320;
  localparam logic [GRID_W-1:0] BLOCK_ROWS_RST = 12'd240;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUTPUT_FORMAT  = 2'd0,
    REG_BLOCKS_PER_ROW = 2'd1,
    REG_BLOCK_ROWS     = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    FMT_RGB888 = 1'b0,
    FMT_RGB565 = 1'b1
  } pix_fmt_t;

  typedef struct packed {
    logic end_of_row;
    logic end_of_frame;
  } grid_flags_t;

  typedef struct packed {
    offset_t r_off;
    offset_t g_off;
    offset_t b_off;
  } chroma_off_t;

endpackage

// ===== rtl/core/y2r_pixel.sv =====
// y2r_pixel: one luma sample plus shared chroma offsets to a packed pixel.
// Depends on y2r_pkg.
`timescale 1ns / 1ps

module y2r_pixel (
  input  logic [y2r_pkg::LUMA_W-1:0]  luma,
  input  y2r_pkg::chroma_off_t        offs,
  input  y2r_pkg::pix_fmt_t           fmt,
  output logic [y2r_pkg::PIXEL_W-1:0] pixel
);

  function automatic logic [7:0] clip_byte(input y2r_pkg::chan_sum_t x);
    logic [7:0] res;
    if (x > y2r_pkg::CLIP_HIGH) begin
      res = 8'hff;
    end else if (x <= y2r_pkg::CLIP_LOW) begin
      res = 8'h00;
    end else begin
      res = x[23:16];
    end
    return res;
  endfunction

  y2r_pkg::chan_sum_t ys;
  logic [7:0] r, g, b;

  always_comb begin
    ys = {3'b000, luma, 16'h0000};
    r  = clip_byte(ys + y2r_pkg::chan_sum_t'(offs.r_off));
    g  = clip_byte(ys + y2r_pkg::chan_sum_t'(offs.g_off));
    b  = clip_byte(ys + y2r_pkg::chan_sum_t'(offs.b_off));
    case (fmt)
      y2r_pkg::FMT_RGB565: pixel = {8'h00, r[7:3], g[7:2], b[7:3]};
      default:             pixel = {r, g, b};
    endcase
  end

endmodule

// ===== rtl/core/y2r_grid.sv =====
// y2r_grid: column and row block counters with end of row / end of frame flags.
// Depends on y2r_pkg.
`timescale 1ns / 1ps

module y2r_grid (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         advance,
  input  logic [y2r_pkg::GRID_W-1:0]   blocks_per_row,
  input  logic [y2r_pkg::GRID_W-1:0]   block_rows,
  output y2r_pkg::grid_flags_t         flags
);

  function automatic logic [y2r_pkg::COUNT_W-1:0] last_index(
    input logic [y2r_pkg::GRID_W-1:0] n
  );
    logic [y2r_pkg::GRID_W-1:0] m;
    m = n;
    if (m == '0) m = 12'd1;
    if (m > y2r_pkg::GRID_MAX) m = y2r_pkg::GRID_MAX;
    m = m - 12'd1;
    return m[y2r_pkg::COUNT_W-1:0];
  endfunction

  logic [y2r_pkg::COUNT_W-1:0] col_r, col_nxt;
  logic [y2r_pkg::COUNT_W-1:0] row_r, row_nxt;

  always_comb begin
    flags.end_of_row   = col_r >= last_index(blocks_per_row);
    flags.end_of_frame = flags.end_of_row && (row_r >= last_index(block_rows));
    col_nxt = col_r;
    row_nxt = row_r;
    if (advance) begin
      if (flags.end_of_row) begin
        col_nxt = '0;
        row_nxt = flags.end_of_frame ? '0 : row_r + 11'd1;
      end else begin
        col_nxt = col_r + 11'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  a_eof_in_eor: assert property (@(posedge clk) disable iff (!rst_n)
    flags.end_of_frame |-> flags.end_of_row)
    else $error("end of frame without end of row");

  a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    advance && flags.end_of_row |=> col_r == '0)
    else $error("column counter did not wrap");

  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !flags.end_of_row |=> col_r == $past(col_r) + 11'd1)
    else $error("column counter did not advance");

endmodule

// ===== rtl/core/yuv420_block_to_rgb.sv =====
// yuv420_block_to_rgb: 2x2 4:2:0 block to four RGB pixels, BT.601 fixed point.
// Depends on y2r_pkg, y2r_pixel and y2r_grid.
//
//   channel | ports                                   | dir
//   in      | in_valid/in_ready, luma x4, chroma x2   | in
//   out     | out_valid/out_ready, pixel x4, flags    | out
//   cfg     | cfg_valid/cfg_ready, cfg_index/cfg_data | in
//
// One block per cycle sustained while out_ready is high; a block goes through
// the input register, then conversion into the result register.
// The conversion between the two registers is a constant multiply per chroma
// term, adds and a clip per channel. cfg_ready is always high.
// Reset is synchronous; it clears valids and counters and sets config defaults.
// A stalled result holds while the input register still takes one more word.
`timescale 1ns / 1ps

module yuv420_block_to_rgb (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [y2r_pkg::LUMA_W-1:0]             in_luma_top_left,
  input  logic [y2r_pkg::LUMA_W-1:0]             in_luma_top_right,
  input  logic [y2r_pkg::LUMA_W-1:0]             in_luma_bottom_left,
  input  logic [y2r_pkg::LUMA_W-1:0]             in_luma_bottom_right,
  input  logic [y2r_pkg::LUMA_W-1:0]             in_chroma_blue,
  input  logic [y2r_pkg::LUMA_W-1:0]             in_chroma_red,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [y2r_pkg::PIXEL_W-1:0]            out_pixel_top_left,
  output logic [y2r_pkg::PIXEL_W-1:0]            out_pixel_top_right,
  output logic [y2r_pkg::PIXEL_W-1:0]            out_pixel_bottom_left,
  output logic [y2r_pkg::PIXEL_W-1:0]            out_pixel_bottom_right,
  output logic                                   out_end_of_row,
  output logic                                   out_end_of_frame,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [y2r_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [y2r_pkg::CFG_DATA_W-1:0]         cfg_data
);

  y2r_pkg::pix_fmt_t               fmt_r;
  logic [y2r_pkg::GRID_W-1:0]      bpr_r;
  logic [y2r_pkg::GRID_W-1:0]      rows_r;

  logic                            s1_valid_r, s1_valid_nxt;
  logic [y2r_pkg::LUMA_W-1:0]      luma_r [4];
  logic [y2r_pkg::LUMA_W-1:0]      cb_r, cr_r;
  y2r_pkg::grid_flags_t            s1_flags_r;

  logic                            out_valid_r, out_valid_nxt;
  logic [y2r_pkg::PIXEL_W-1:0]     pix_r [4];
  y2r_pkg::grid_flags_t            out_flags_r;

  logic                            in_acc, s1_adv, out_load;
  y2r_pkg::grid_flags_t            grid_flags;
  y2r_pkg::chroma_off_t            offs;
  y2r_pkg::offset_t                u_ext, v_ext;
  logic [y2r_pkg::PIXEL_W-1:0]     pix_w [4];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r  <= y2r_pkg::FMT_RGB888;
      bpr_r  <= y2r_pkg::BLOCKS_PER_ROW_RST;
      rows_r <= y2r_pkg::BLOCK_ROWS_RST;
    end else if (cfg_valid) begin
      case (y2r_pkg::cfg_reg_t'(cfg_index))
        y2r_pkg::REG_OUTPUT_FORMAT:  fmt_r  <= y2r_pkg::pix_fmt_t'(cfg_data[0]);
        y2r_pkg::REG_BLOCKS_PER_ROW: bpr_r  <= cfg_data;
        y2r_pkg::REG_BLOCK_ROWS:     rows_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    out_load      = !out_valid_r || out_ready;
    s1_adv        = s1_valid_r && out_load;
    in_ready      = !s1_valid_r || out_load;
    in_acc        = in_valid && in_ready;
    s1_valid_nxt  = in_acc || (s1_valid_r && !out_load);
    out_valid_nxt = s1_adv || (out_valid_r && !out_ready);
  end

  y2r_grid u_grid (
    .clk            (clk),
    .rst_n          (rst_n),
    .advance        (in_acc),
    .blocks_per_row (bpr_r),
    .block_rows     (rows_r),
    .flags          (grid_flags)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      luma_r[0]  <= in_luma_top_left;
      luma_r[1]  <= in_luma_top_right;
      luma_r[2]  <= in_luma_bottom_left;
      luma_r[3]  <= in_luma_bottom_right;
      cb_r       <= in_chroma_blue;
      cr_r       <= in_chroma_red;
      s1_flags_r <= grid_flags;
    end
  end

  // center chroma: x - 128 equals the byte with its top bit flipped, as signed
  always_comb begin
    u_ext      = y2r_pkg::offset_t'($signed(cb_r ^ 8'h80));
    v_ext      = y2r_pkg::offset_t'($signed(cr_r ^ 8'h80));
    offs.r_off = y2r_pkg::COEF_RV * v_ext;
    offs.g_off = y2r_pkg::COEF_GU * u_ext + y2r_pkg::COEF_GV * v_ext;
    offs.b_off = y2r_pkg::COEF_BU * u_ext;
  end

  for (genvar i = 0; i < 4; i++) begin : g_pix
    y2r_pixel u_pixel (
      .luma  (luma_r[i]),
      .offs  (offs),
      .fmt   (fmt_r),
      .pixel (pix_w[i])
    );
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      for (int i = 0; i < 4; i++) begin
        pix_r[i] <= pix_w[i];
      end
      out_flags_r <= s1_flags_r;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_pixel_top_left     = pix_r[0];
  assign out_pixel_top_right    = pix_r[1];
  assign out_pixel_bottom_left  = pix_r[2];
  assign out_pixel_bottom_right = pix_r[3];
  assign out_end_of_row         = out_flags_r.end_of_row;
  assign out_end_of_frame       = out_flags_r.end_of_frame;

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ready)
    else $error("input stalled with room in the pipeline");

  a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result appeared without a staged word");

endmodule
